>>> design/voxel_risk_map_collision_check_macros.svh
// assertion macros for the voxel risk map collision check
// no dependencies, the modules that use them provide i_clk and i_rst_n
`ifndef VOXEL_RISK_MAP_COLLISION_CHECK_MACROS_SVH
`define VOXEL_RISK_MAP_COLLISION_CHECK_MACROS_SVH

// same-cycle implication, checked at every clock edge outside reset
`define VRM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VRM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/vrm_pkg.sv
// shared types and constants of the voxel risk map collision check
// no dependencies
package vrm_pkg;

    // transaction kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_ADD   = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // query status codes
    localparam logic [1:0] STATUS_FREE      = 2'd0;
    localparam logic [1:0] STATUS_COLLISION = 2'd1;
    localparam logic [1:0] STATUS_OOB       = 2'd2;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_RADIUS    = 1'b1;

    localparam logic [15:0] RISK_ONE = 16'd256;
    localparam logic [15:0] RISK_MAX = 16'hFFFF;
    localparam logic [15:0] THRESHOLD_RESET = 16'd128;
    localparam logic [1:0]  RADIUS_RESET = 2'd1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [7:0]  voxel_x;
        logic signed [7:0]  voxel_y;
        logic signed [7:0]  voxel_z;
        logic [7:0]         frame;
        logic [15:0]        risk;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] risk_sum;
    } t_result;

endpackage

>>> design/vrm_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module vrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/voxel_risk_map_collision_check.sv
// voxel risk map with clearance-kernel collision check, top level
// depends on vrm_pkg, vrm_ram and voxel_risk_map_collision_check_macros.svh
//
// usage:
// - a transaction is taken at a rising edge with start high and busy low; i_item
//   carries kind, voxel coordinates, frame and risk amount
// - only a query gives a result: o_valid is high for exactly one cycle with o_result;
//   the receiver cannot stall, so the result must be taken in that cycle
// - mark: written on acceptance, busy stays low; add: a read, then a saturating write back, busy high meanwhile
// - query with out-of-range center: result in the next cycle, busy stays low
// - query in range: one kernel voxel read per cycle from the risk memory, pipelined
//   against the accumulator over n = (2*radius+1)^2 neighbors; the result follows the
//   last neighbor's accumulation, earlier when the sum passes the threshold
// - clear and reset: a clearing pass writes zero to every memory entry, one a cycle,
//   over 2^(XW+YW+ZW+FW) entries (65536 at the default grid), busy high meanwhile
// - configuration writes (threshold, radius) are registered and not gated by busy, so
//   they also take effect during the clearing pass after reset
// - the memory address packs the voxel fields side by side, each rounded up to a
//   power of two, so no address arithmetic is needed
module voxel_risk_map_collision_check
    import vrm_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 16,
    parameter int FRAMES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

`include "voxel_risk_map_collision_check_macros.svh"

    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int AW = XW + YW + ZW + FW;

    localparam logic signed [9:0] LIM_X = 10'(GRID_X);
    localparam logic signed [9:0] LIM_Y = 10'(GRID_Y);
    localparam logic signed [9:0] LIM_Z = 10'(GRID_Z);
    localparam logic [7:0] FRAME_LAST = 8'(FRAMES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_QUERY = 2'd3;

    function automatic logic [AW-1:0] f_addr(
        input logic [XW-1:0] x,
        input logic [YW-1:0] y,
        input logic [ZW-1:0] z,
        input logic [FW-1:0] f
    );
        return {x, y, z, f};
    endfunction

    function automatic logic [15:0] f_sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? RISK_MAX : s[15:0];
    endfunction

    // control state
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_iss, n_iss;
    logic          r_pv, n_pv;
    logic          r_plast, n_plast;
    logic          r_valid, n_valid;
    logic [15:0]   r_threshold;
    logic [1:0]    r_radius;

    // payload
    logic [AW-1:0]      r_addr, n_addr;
    logic [15:0]        r_risk, n_risk;
    logic signed [9:0]  r_cx, n_cx;
    logic signed [9:0]  r_cy, n_cy;
    logic [ZW-1:0]      r_cz, n_cz;
    logic [FW-1:0]      r_cf, n_cf;
    logic [1:0]         r_rad, n_rad;
    logic signed [2:0]  r_dx, n_dx;
    logic signed [2:0]  r_dy, n_dy;
    logic [15:0]        r_acc, n_acc;
    t_result            r_result, n_result;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // input decode
    logic signed [9:0] in_x, in_y, in_z;
    logic              in_vox_ok, in_frame_ok;
    logic [7:0]        in_fq;
    logic [AW-1:0]     in_addr;

    assign in_x = {{2{i_item.voxel_x[7]}}, i_item.voxel_x};
    assign in_y = {{2{i_item.voxel_y[7]}}, i_item.voxel_y};
    assign in_z = {{2{i_item.voxel_z[7]}}, i_item.voxel_z};
    assign in_vox_ok = (in_x >= 0) && (in_x < LIM_X) && (in_y >= 0) && (in_y < LIM_Y)
                    && (in_z >= 0) && (in_z < LIM_Z);
    assign in_frame_ok = (i_item.frame <= FRAME_LAST);
    assign in_fq = in_frame_ok ? i_item.frame : FRAME_LAST;
    assign in_addr = f_addr(in_x[XW-1:0], in_y[YW-1:0], in_z[ZW-1:0], i_item.frame[FW-1:0]);

    // kernel neighbor
    logic signed [9:0] nb_x, nb_y;
    logic signed [2:0] rad_pos, rad_neg;
    logic              nb_ok, nb_last;
    logic [AW-1:0]     nb_addr;

    assign rad_pos = $signed({1'b0, r_rad});
    assign rad_neg = -rad_pos;
    assign nb_x = r_cx + {{7{r_dx[2]}}, r_dx};
    assign nb_y = r_cy + {{7{r_dy[2]}}, r_dy};
    assign nb_ok = (nb_x >= 0) && (nb_x < LIM_X) && (nb_y >= 0) && (nb_y < LIM_Y);
    assign nb_last = (r_dx == rad_pos) && (r_dy == rad_pos);
    assign nb_addr = f_addr(nb_x[XW-1:0], nb_y[YW-1:0], r_cz, r_cf);

    // accumulator stage, in the cycle after the read
    logic [15:0] acc_new;
    logic        acc_hit;

    assign acc_new = r_pv ? f_sat_add(r_acc, ram_rdata) : r_acc;
    assign acc_hit = r_pv && (acc_new > r_threshold);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_iss      = r_iss;
        n_pv       = 1'b0;
        n_plast    = 1'b0;
        n_valid    = 1'b0;
        n_addr     = r_addr;
        n_risk     = r_risk;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_cz       = r_cz;
        n_cf       = r_cf;
        n_rad      = r_rad;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_acc      = r_acc;
        n_result   = r_result;
        ram_we     = 1'b0;
        ram_waddr  = r_clr_addr;
        ram_wdata  = '0;
        ram_raddr  = in_addr;

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_raddr = in_addr;
                if (start) begin
                    case (i_item.kind)
                        KIND_CLEAR: begin
                            n_state    = ST_CLEAR;
                            n_clr_addr = '0;
                        end
                        KIND_MARK: begin
                            if (in_vox_ok && in_frame_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = in_addr;
                                ram_wdata = RISK_ONE;
                            end
                        end
                        KIND_ADD: begin
                            if (in_vox_ok && in_frame_ok) begin
                                n_state = ST_ADD;
                                n_addr  = in_addr;
                                n_risk  = i_item.risk;
                            end
                        end
                        KIND_QUERY: begin
                            if (!in_vox_ok) begin
                                n_valid           = 1'b1;
                                n_result.status   = STATUS_OOB;
                                n_result.risk_sum = '0;
                            end else begin
                                n_state = ST_QUERY;
                                n_cx    = in_x;
                                n_cy    = in_y;
                                n_cz    = in_z[ZW-1:0];
                                n_cf    = in_fq[FW-1:0];
                                n_rad   = r_radius;
                                n_dx    = -$signed({1'b0, r_radius});
                                n_dy    = -$signed({1'b0, r_radius});
                                n_iss   = 1'b1;
                                n_acc   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD: begin
                // read data of the entry arrives now, write back the saturated sum
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = f_sat_add(ram_rdata, r_risk);
                n_state   = ST_IDLE;
            end
            ST_QUERY: begin
                ram_raddr = nb_addr;
                n_pv      = r_iss && nb_ok;
                n_plast   = r_iss && nb_last;
                if (r_iss) begin
                    if (nb_last) begin
                        n_iss = 1'b0;
                    end else if (r_dy == rad_pos) begin
                        n_dy = rad_neg;
                        n_dx = r_dx + 3'sd1;
                    end else begin
                        n_dy = r_dy + 3'sd1;
                    end
                end
                n_acc = acc_new;
                // reads still in flight are dropped when the query ends early
                if (acc_hit) begin
                    n_valid           = 1'b1;
                    n_result.status   = STATUS_COLLISION;
                    n_result.risk_sum = acc_new;
                    n_state           = ST_IDLE;
                    n_iss             = 1'b0;
                end else if (r_plast) begin
                    n_valid           = 1'b1;
                    n_result.status   = STATUS_FREE;
                    n_result.risk_sum = acc_new;
                    n_state           = ST_IDLE;
                    n_iss             = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_iss       <= 1'b0;
            r_pv        <= 1'b0;
            r_plast     <= 1'b0;
            r_valid     <= 1'b0;
            r_threshold <= THRESHOLD_RESET;
            r_radius    <= RADIUS_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_iss      <= n_iss;
            r_pv       <= n_pv;
            r_plast    <= n_plast;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_RADIUS:    r_radius <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_risk   <= n_risk;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_cz     <= n_cz;
        r_cf     <= n_cf;
        r_rad    <= n_rad;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_acc    <= n_acc;
        r_result <= n_result;
    end

    vrm_ram #(
        .WIDTH(16),
        .DEPTH(2 ** AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `VRM_ASSERT_NXT(a_clear_holds_busy, start && !busy && i_item.kind == KIND_CLEAR, busy, "clear did not start the clearing pass")
    `VRM_ASSERT_NXT(a_clear_runs_to_end, r_state == ST_CLEAR && r_clr_addr != '1, r_state == ST_CLEAR, "clearing pass left early")
    `VRM_ASSERT_IMP(a_oob_sum_zero, o_valid && o_result.status == STATUS_OOB, o_result.risk_sum == '0, "out of bound result with nonzero sum")
    `VRM_ASSERT_IMP(a_collision_above, o_valid && o_result.status == STATUS_COLLISION, o_result.risk_sum > r_threshold, "collision reported at or below threshold")
    `VRM_ASSERT_IMP(a_free_below, o_valid && o_result.status == STATUS_FREE, o_result.risk_sum <= r_threshold, "free reported above threshold")

endmodule

>>> verif/tb.sv
// testbench for voxel_risk_map_collision_check: directed table, then random phases
// depends on vrm_pkg and the voxel_risk_map_collision_check top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vrm_pkg::*;

    localparam int GRID_X = 32;
    localparam int GRID_Y = 32;
    localparam int GRID_Z = 16;
    localparam int FRAMES = 4;
    localparam int MAP_DEPTH = GRID_X * GRID_Y * GRID_Z * FRAMES;

    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT = 27;
    // widest kernel plus pipeline, rounded up
    localparam int SETTLE_CYCLES = 64;
    // a clearing pass runs over the whole map with nothing accepted
    localparam int WATCHDOG_LIMIT = 4 * 65536;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 228;
    localparam int NO_IDLE_PHASE = 4;
    localparam int DRAIN_PHASE = 1;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    // shadow of the block: risk store and registers
    logic [15:0] shadow_store [0:MAP_DEPTH-1];
    logic [15:0] threshold_shadow;
    logic [1:0]  radius_shadow;

    t_result pending_results [$];
    t_result got_result;
    t_result want_result;
    t_row    directed_rows [$];
    int      errors = 0;
    int      stall_cycles = 0;
    int      idle_pct;

    voxel_risk_map_collision_check #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z),
        .FRAMES(FRAMES)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic bit voxel_in_grid(input int x, input int y, input int z);
        return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
    endfunction

    function automatic int cell_index(input int x, input int y, input int z, input int f);
        return ((x * GRID_Y + y) * GRID_Z + z) * FRAMES + f;
    endfunction

    function automatic void queue_expected(input t_result res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    // updates the shadow store; returns 1 with the kernel check outcome for a query
    function automatic bit kernel_check(input t_item it, output t_result res);
        int x, y, z, f, r, dx, dy, idx;
        int unsigned sum;
        x = $signed(it.voxel_x);
        y = $signed(it.voxel_y);
        z = $signed(it.voxel_z);
        f = it.frame;
        res = '0;
        case (it.kind)
            KIND_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = '0;
                return 1'b0;
            end
            KIND_MARK, KIND_ADD: begin
                if (voxel_in_grid(x, y, z) && f < FRAMES) begin
                    idx = cell_index(x, y, z, f);
                    if (it.kind == KIND_MARK) begin
                        shadow_store[idx] = RISK_ONE;
                    end else begin
                        sum = 32'(shadow_store[idx]) + 32'(it.risk);
                        shadow_store[idx] = (sum > RISK_MAX) ? RISK_MAX : sum[15:0];
                    end
                end
                return 1'b0;
            end
            default: begin
                if (f > FRAMES - 1) f = FRAMES - 1;
                if (!voxel_in_grid(x, y, z)) begin
                    res.status = STATUS_OOB;
                    res.risk_sum = '0;
                    return 1'b1;
                end
                r = radius_shadow;
                sum = 0;
                for (dx = -r; dx <= r; dx++) begin
                    for (dy = -r; dy <= r; dy++) begin
                        if (voxel_in_grid(x + dx, y + dy, z)) begin
                            sum += shadow_store[cell_index(x + dx, y + dy, z, f)];
                            if (sum > RISK_MAX) sum = RISK_MAX;
                            // stops at the first neighbor that pushes the sum over
                            if (sum > threshold_shadow) begin
                                res.status = STATUS_COLLISION;
                                res.risk_sum = sum[15:0];
                                return 1'b1;
                            end
                        end
                    end
                end
                res.status = STATUS_FREE;
                res.risk_sum = sum[15:0];
                return 1'b1;
            end
        endcase
    endfunction

    function automatic t_row mk_row(input logic [1:0] kind, input int x, input int y,
                                    input int z, input int f, input int risk,
                                    input bit typed, input logic [1:0] status,
                                    input int sum);
        t_row row;
        row.it.kind = kind;
        row.it.voxel_x = 8'(x);
        row.it.voxel_y = 8'(y);
        row.it.voxel_z = 8'(z);
        row.it.frame = 8'(f);
        row.it.risk = 16'(risk);
        row.typed = typed;
        row.res.status = status;
        row.res.risk_sum = 16'(sum);
        return row;
    endfunction

    function automatic void append_row(input t_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // mostly writes and queries around a small cluster, some full-range noise
    function automatic t_item rand_item(input int bx, input int by, input int bz);
        t_item it;
        int pick;
        pick = $urandom_range(99);
        if (pick >= 90) begin
            it.kind = 2'($urandom_range(1, 3));
            it.voxel_x = 8'($urandom);
            it.voxel_y = 8'($urandom);
            it.voxel_z = 8'($urandom);
            it.frame = 8'($urandom);
            it.risk = 16'($urandom);
            return it;
        end
        if (pick < 42) it.kind = KIND_QUERY;
        else if (pick < 68) it.kind = KIND_ADD;
        else it.kind = KIND_MARK;
        if ($urandom_range(9) == 0) begin
            it.voxel_x = 8'($urandom_range(0, GRID_X - 1));
            it.voxel_y = 8'($urandom_range(0, GRID_Y - 1));
            it.voxel_z = 8'($urandom_range(0, GRID_Z - 1));
        end else begin
            it.voxel_x = 8'(bx + $urandom_range(0, 7) - 1);
            it.voxel_y = 8'(by + $urandom_range(0, 7) - 1);
            it.voxel_z = 8'(bz + $urandom_range(0, 1));
        end
        it.frame = ($urandom_range(99) < 85) ? 8'($urandom_range(0, FRAMES - 1)) : 8'($urandom);
        case ($urandom_range(3))
            0: it.risk = 16'($urandom_range(0, 300));
            1: it.risk = 16'($urandom);
            2: it.risk = RISK_MAX;
            default: it.risk = 16'($urandom_range(0, 3000));
        endcase
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge with the transaction taken
    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        t_result res;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (kernel_check(it, res)) queue_expected(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained(input bit settle);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        if (settle) begin
            // marks and adds give no result, so let the block finish them
            while (busy) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] thr, input logic [1:0] rad);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_THRESHOLD;
        i_cfg_data <= thr;
        @(negedge i_clk);
        i_cfg_idx <= CFG_RADIUS;
        i_cfg_data <= {14'($urandom), rad};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        threshold_shadow = thr;
        radius_shadow = rad;
    endtask

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got_result = o_result;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, status %0d sum %0d",
                         $time, got_result.status, got_result.risk_sum);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.status != want_result.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want_result.status, got_result.status);
                end
                if (got_result.risk_sum != want_result.risk_sum) begin
                    errors++;
                    $display("%0t: risk_sum expected %0d actual %0d", $time,
                             want_result.risk_sum, got_result.risk_sum);
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [15:0] thr;
        logic [1:0]  rad;
        int          bx, by, bz;
        t_item       it;
        t_result     no_res;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_THRESHOLD;
        i_cfg_data = '0;
        idle_pct = IDLE_PCT;
        no_res = '0;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        threshold_shadow = THRESHOLD_RESET;
        radius_shadow = RADIUS_RESET;

        // reset registers: threshold 0.5, radius 1, store empty
        append_row(mk_row(KIND_QUERY, 0, 0, 0, 0, 0, 1, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, -128, 0, 0, 0, 0, 1, STATUS_OOB, 0));
        append_row(mk_row(KIND_QUERY, 32, 5, 5, 0, 0, 1, STATUS_OOB, 0));
        append_row(mk_row(KIND_QUERY, 5, -1, 5, 0, 0, 1, STATUS_OOB, 0));
        append_row(mk_row(KIND_QUERY, 5, 5, 16, 0, 0, 1, STATUS_OOB, 0));
        append_row(mk_row(KIND_QUERY, 127, 127, 127, 255, 65535, 1,
                          STATUS_OOB, 0));
        // frame clamped to the last one
        append_row(mk_row(KIND_QUERY, 31, 31, 15, 255, 0, 1, STATUS_FREE, 0));
        append_row(mk_row(KIND_MARK, 5, 5, 5, 0, 65535, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 5, 5, 5, 0, 0, 1, STATUS_COLLISION, 256));
        // add saturates at the top of the range
        append_row(mk_row(KIND_ADD, 6, 6, 5, 1, 65535, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_ADD, 6, 6, 5, 1, 1, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 6, 6, 5, 1, 0, 1, STATUS_COLLISION,
                          65535));
        // writes outside the grid or the frames are dropped
        append_row(mk_row(KIND_ADD, 7, 7, 5, 4, 'h1234, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_MARK, -1, 0, 0, 0, 0, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_MARK, 0, 0, -128, 0, 0, 0, STATUS_FREE, 0));
        // corner query, out-of-grid neighbors skipped
        append_row(mk_row(KIND_MARK, 0, 0, 0, 2, 0, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 0, 0, 0, 2, 0, 1, STATUS_COLLISION, 256));
        append_row(mk_row(KIND_QUERY, 7, 7, 5, 0, 0, 1, STATUS_FREE, 0));
        append_row(mk_row(KIND_ADD, 4, 4, 5, 0, 0, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_ADD, 4, 5, 5, 0, 'h50, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 5, 5, 5, 0, 0, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 4, 5, 5, 3, 0, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 5, 5, 5, 0, 0, 1, STATUS_FREE, 0));
        append_row(mk_row(KIND_QUERY, 6, 6, 5, 1, 0, 1, STATUS_FREE, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n])
            send_item(directed_rows[n].it, directed_rows[n].typed, directed_rows[n].res);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            hold_until_drained(1'b1);
            case (phase)
                0: begin thr = 16'd0;     rad = 2'd0; end
                1: begin thr = 16'd128;   rad = 2'd1; end
                2: begin thr = RISK_MAX;  rad = 2'd3; end
                3: begin thr = 16'($urandom);  rad = 2'd2; end
                4: begin thr = 16'd1000;  rad = 2'd3; end
                5: begin thr = RISK_MAX;  rad = 2'd0; end
                6: begin thr = 16'($urandom);  rad = 2'($urandom); end
                default: begin thr = 16'd3000; rad = 2'd2; end
            endcase
            write_regs(thr, rad);
            idle_pct = (phase == NO_IDLE_PHASE) ? 0 : IDLE_PCT;
            // cluster at the low edge, the high edge or somewhere inside
            case (phase % 3)
                0: begin bx = 0; by = 0; bz = 0; end
                1: begin bx = GRID_X - 6; by = GRID_Y - 6; bz = GRID_Z - 2; end
                default: begin
                    bx = $urandom_range(0, GRID_X - 6);
                    by = $urandom_range(0, GRID_Y - 6);
                    bz = $urandom_range(0, GRID_Z - 2);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == DRAIN_PHASE && n == PHASE_ITEMS / 2)
                    hold_until_drained(1'b0);
                if ((phase == 2 || phase == 5) && n == PHASE_ITEMS / 2) begin
                    it = rand_item(bx, by, bz);
                    it.kind = KIND_CLEAR;
                end else begin
                    it = rand_item(bx, by, bz);
                end
                send_item(it, 1'b0, no_res);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/vrm_pkg.sv
design/vrm_ram.sv
design/voxel_risk_map_collision_check.sv
verif/tb.sv
